FILE: hw/rtl/credit_switch_allocator_5port_unit_macros.svh
// Assertion helpers used by the allocator top-level RTL.
`ifndef CREDIT_SWITCH_ALLOCATOR_5PORT_UNIT_MACROS_SVH
`define CREDIT_SWITCH_ALLOCATOR_5PORT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define CSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

FILE: hw/rtl/csa_pkg.sv
`default_nettype none
package csa_pkg;

   localparam int NUM_PORTS  = 5;
   localparam int NUM_REQ    = 4;
   localparam int CFG_W      = 4;
   localparam int CREDIT_MAX = 15;
   localparam int CNT_W      = $clog2(CREDIT_MAX + 1);
   localparam int CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   // port order: L=0, N=1, S=2, E=3, W=4
   localparam int PORT_L = 0;
   localparam int PORT_N = 1;
   localparam int PORT_S = 2;
   localparam int PORT_E = 3;
   localparam int PORT_W = 4;

   localparam logic [CFG_W-1:0] INIT_CREDITS_RST = 4'd4;

   // one-hot grant codes, MSB is the first requester
   localparam logic [NUM_REQ-1:0] GNT_REQ0 = 4'b1000;
   localparam logic [NUM_REQ-1:0] GNT_REQ1 = 4'b0100;
   localparam logic [NUM_REQ-1:0] GNT_REQ2 = 4'b0010;
   localparam logic [NUM_REQ-1:0] GNT_REQ3 = 4'b0001;
   localparam logic [NUM_REQ-1:0] GNT_IDLE = 4'b0000;

   typedef logic [NUM_REQ-1:0] grant_type;
   typedef logic [CNT_W-1:0]   credit_type;

   typedef struct packed {
      grant_type grant;     // grant after this step
      logic      cnt_zero;  // counter currently empty
   } lane_status_type;

   function automatic credit_type clamp_credit(input logic [CFG_W-1:0] v);
      if (CMP_W'(v) > CMP_W'(CREDIT_MAX)) begin
         return CNT_W'(CREDIT_MAX);
      end
      return CNT_W'(v);
   endfunction

   // port number of requester i of output o (the output skips itself)
   function automatic int req_port(input int o, input int i);
      return (i < o) ? i : i + 1;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/csa_req_if.sv
`default_nettype none
interface csa_req_if import csa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [NUM_REQ-1:0]   req_to_local;
   logic [NUM_REQ-1:0]   req_to_north;
   logic [NUM_REQ-1:0]   req_to_south;
   logic [NUM_REQ-1:0]   req_to_east;
   logic [NUM_REQ-1:0]   req_to_west;
   logic [NUM_PORTS-1:0] credit_return;

   modport source (
      output valid, req_to_local, req_to_north, req_to_south, req_to_east,
             req_to_west, credit_return,
      input  ready
   );
   modport sink (
      input  valid, req_to_local, req_to_north, req_to_south, req_to_east,
             req_to_west, credit_return,
      output ready
   );
endinterface
`default_nettype wire

FILE: hw/rtl/csa_rsp_if.sv
`default_nettype none
interface csa_rsp_if import csa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [NUM_REQ-1:0]   grant_local;
   logic [NUM_REQ-1:0]   grant_north;
   logic [NUM_REQ-1:0]   grant_south;
   logic [NUM_REQ-1:0]   grant_east;
   logic [NUM_REQ-1:0]   grant_west;
   logic [NUM_PORTS-1:0] send_request;

   modport source (
      output valid, grant_local, grant_north, grant_south, grant_east,
             grant_west, send_request,
      input  ready
   );
   modport sink (
      input  valid, grant_local, grant_north, grant_south, grant_east,
             grant_west, send_request,
      output ready
   );
endinterface
`default_nettype wire

FILE: hw/rtl/csa_lane.sv
`default_nettype none
// One output port: grant holder and credit counter.
module csa_lane import csa_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire grant_type       req_bits,
   input  wire logic            credit_in,
   input  wire logic            load,
   input  wire credit_type      load_value,
   output lane_status_type      status
);

   grant_type  grant_ff, grant_in;
   credit_type cnt_ff, cnt_in;
   grant_type  hold;
   grant_type  pick;

   always_comb begin
      hold = grant_ff & req_bits;
      if (req_bits[3])      pick = GNT_REQ0;
      else if (req_bits[2]) pick = GNT_REQ1;
      else if (req_bits[1]) pick = GNT_REQ2;
      else if (req_bits[0]) pick = GNT_REQ3;
      else                  pick = GNT_IDLE;

      if (cnt_ff == '0)  grant_in = GNT_IDLE;
      else if (|hold)    grant_in = hold;
      else               grant_in = pick;

      cnt_in = cnt_ff;
      if (grant_in == GNT_IDLE) begin
         if (credit_in && cnt_ff != CNT_W'(CREDIT_MAX)) cnt_in = cnt_ff + 1'b1;
      end else if (!credit_in && cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grant_ff <= GNT_IDLE;
         cnt_ff   <= clamp_credit(INIT_CREDITS_RST);
      end else if (load) begin
         cnt_ff   <= load_value;  // grant holder kept
      end else if (step) begin
         grant_ff <= grant_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign status.grant    = grant_in;
   assign status.cnt_zero = (cnt_ff == '0);

endmodule
`default_nettype wire

FILE: hw/rtl/csa_merge.sv
`default_nettype none
// Folds the per-output grants into the per-input send vector (L is MSB).
module csa_merge import csa_pkg::*; (
   input  wire grant_type            grants [NUM_PORTS],
   output logic [NUM_PORTS-1:0]      send_request
);

   always_comb begin
      send_request = '0;
      for (int o = 0; o < NUM_PORTS; o++) begin
         for (int i = 0; i < NUM_REQ; i++) begin
            if (grants[o][NUM_REQ-1-i]) begin
               send_request[NUM_PORTS-1-req_port(o, i)] = 1'b1;
            end
         end
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/credit_switch_allocator_5port_unit.sv
// Credit-based switch allocator for a five-port mesh router (L, N, S, E, W).
// req_chan: one word per clock tick while req_chan.ready is high, carrying, per
//   output, the four request bits of the other ports (first requester in the
//   MSB) and one credit return bit per output (L in the MSB).
// rsp_chan: one word per accepted request word: the one-hot grant of each
//   output after the tick (zero when idle) and send_request, the per-input
//   OR of all grants (L in the MSB).
// csr_wr_en/csr_wr_data: initial credit count; a write reloads every credit
//   counter at once and leaves grant holders alone. Write only when idle.
// Latency: the response word is valid the cycle after the request word is
//   accepted. Throughput: one word per cycle while the response register is
//   free; all five output lanes update together on each accepted word.
// Reset: every output idle, every counter loaded with 4 (limited to the
//   counter maximum).
// Stall: the response register holds its word while rsp_chan.ready is low;
//   a new request is taken in the same cycle the held word drains, and none
//   is taken while the held word waits.
`default_nettype none
`include "credit_switch_allocator_5port_unit_macros.svh"
module credit_switch_allocator_5port_unit import csa_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   csa_req_if.sink                req_chan,
   csa_rsp_if.source              rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire logic [CFG_W-1:0]  csr_wr_data
);

   logic            req_accept;
   logic            rsp_valid_ff, rsp_valid_in;
   grant_type       req_bits   [NUM_PORTS];
   grant_type       lane_grant [NUM_PORTS];
   lane_status_type lane_stat  [NUM_PORTS];
   grant_type       grant_ff   [NUM_PORTS];
   logic [NUM_PORTS-1:0] send_in, send_ff;
   credit_type      load_value;

   // Output register frees up when empty or draining this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign load_value     = clamp_credit(csr_wr_data);

   assign req_bits[PORT_L] = req_chan.req_to_local;
   assign req_bits[PORT_N] = req_chan.req_to_north;
   assign req_bits[PORT_S] = req_chan.req_to_south;
   assign req_bits[PORT_E] = req_chan.req_to_east;
   assign req_bits[PORT_W] = req_chan.req_to_west;

   // One lane per output port; credit_return has L in the MSB.
   for (genvar o = 0; o < NUM_PORTS; o++) begin : g_lane
      csa_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .step       (req_accept),
         .req_bits   (req_bits[o]),
         .credit_in  (req_chan.credit_return[NUM_PORTS-1-o]),
         .load       (csr_wr_en),
         .load_value (load_value),
         .status     (lane_stat[o])
      );
      assign lane_grant[o] = lane_stat[o].grant;
   end

   csa_merge u_merge (
      .grants       (lane_grant),
      .send_request (send_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept)          rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         grant_ff <= lane_grant;
         send_ff  <= send_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.grant_local  = grant_ff[PORT_L];
   assign rsp_chan.grant_north  = grant_ff[PORT_N];
   assign rsp_chan.grant_south  = grant_ff[PORT_S];
   assign rsp_chan.grant_east   = grant_ff[PORT_E];
   assign rsp_chan.grant_west   = grant_ff[PORT_W];
   assign rsp_chan.send_request = send_ff;

   // Every accepted word shows up at the output next cycle.
   `CSA_ASSERT_NEXT(a_rsp_after_accept, clock, reset, req_accept, rsp_valid_ff)
   // The local output grants nothing while its counter is empty.
   `CSA_ASSERT_NEXT(a_no_credit_no_grant, clock, reset,
      req_accept && lane_stat[PORT_L].cnt_zero, grant_ff[PORT_L] == GNT_IDLE)
   // Local, north and west grants are one-hot or idle.
   `CSA_ASSERT_NOW(a_grant_onehot, clock, reset, rsp_valid_ff,
      $onehot0(grant_ff[PORT_L]) && $onehot0(grant_ff[PORT_N]) && $onehot0(grant_ff[PORT_W]))
   // Local send bit is the OR of the other outputs' first-requester grants.
   `CSA_ASSERT_NOW(a_send_local, clock, reset, rsp_valid_ff,
      send_ff[NUM_PORTS-1] == (grant_ff[PORT_N][3] || grant_ff[PORT_S][3] ||
                               grant_ff[PORT_E][3] || grant_ff[PORT_W][3]))

endmodule
`default_nettype wire
